/* rtl/pfed_pkg.sv */
// shared types, constants and fixed-point helpers for the phase-field energy derivative
package pfed_pkg;

  typedef logic signed [31:0] q_t;
  typedef logic signed [63:0] wide_t;

  localparam int unsigned AddrW = 5;

  localparam wide_t QOne    = 64'sd16777216;
  localparam wide_t QHalf   = 64'sd8388608;
  localparam wide_t SatMax  = 64'sd2147483647;
  localparam wide_t SatMin  = -64'sd2147483648;

  localparam q_t CoefAlphaRst     = 32'sd16777216;
  localparam q_t CoefBetaRst      = 32'sd16777216;
  localparam q_t CompAlphaRst     = 32'sd0;
  localparam q_t CompBetaOneRst   = 32'sd0;
  localparam q_t CompBetaTwoRst   = 32'sd16777216;
  localparam q_t CouplingChiRst   = 32'sd0;
  localparam q_t BarrierHeightRst = 32'sd0;

  typedef enum logic [2:0] {
    RegCoefAlpha     = 3'd0,
    RegCoefBeta      = 3'd1,
    RegCompAlpha     = 3'd2,
    RegCompBetaOne   = 3'd3,
    RegCompBetaTwo   = 3'd4,
    RegCouplingChi   = 3'd5,
    RegBarrierHeight = 3'd6
  } reg_idx_e;

  function automatic wide_t wext(input q_t a);
    return {{32{a[31]}}, a};
  endfunction

  function automatic q_t sat(input wide_t x);
    if (x > SatMax) begin
      return q_t'(SatMax[31:0]);
    end else if (x < SatMin) begin
      return q_t'(SatMin[31:0]);
    end
    return x[31:0];
  endfunction

  // rounded Q8.24 product, half up, saturated
  function automatic q_t qmul(input q_t a, input q_t b);
    wide_t p;
    p = wext(a) * wext(b) + QHalf;
    return sat(p >>> 24);
  endfunction

endpackage

/* rtl/pfed_in_if.sv */
// input channel: composition and phase value words
interface pfed_in_if;
  import pfed_pkg::*;

  logic valid;
  logic ready;
  q_t   composition;
  q_t   phase_value;

  modport source (output valid, output composition, output phase_value, input ready);
  modport sink   (input valid, input composition, input phase_value, output ready);
endinterface

/* rtl/pfed_out_if.sv */
// output channel: interpolation and free energy derivative words
interface pfed_out_if;
  import pfed_pkg::*;

  logic valid;
  logic ready;
  q_t   interp_h;
  q_t   deriv_comp;
  q_t   deriv_phase;

  modport source (output valid, output interp_h, output deriv_comp, output deriv_phase,
                  input ready);
  modport sink   (input valid, input interp_h, input deriv_comp, input deriv_phase,
                  output ready);
endinterface

/* rtl/phase_field_energy_derivative.sv */
// phase-field free energy derivative, eight-stage pipeline with apb register port
//
//   channel   dir   handshake        word
//   in_i      in    valid/ready      composition, phase_value (Q8.24)
//   out_o     out   valid/ready      interp_h, deriv_comp, deriv_phase (Q8.24)
//   apb       in    psel/penable     seven 32-bit registers at 4*index
//
// one word per cycle while out_o is not stalled; each word passes through the
// difference stage, six product stages and the final sum stage to out_o.valid
// reset clears the stage valid bits and loads the register defaults
// the whole pipe advances whenever the last stage is empty or being taken, so a
// stall on out_o freezes every stage and back-pressures in_i in the same cycle
module phase_field_energy_derivative (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [pfed_pkg::AddrW-1:0] paddr,
  input  logic [31:0]             pwdata,
  output logic [31:0]             prdata,
  output logic                    pready,
  pfed_in_if.sink                 in_i,
  pfed_out_if.source              out_o
);
  import pfed_pkg::*;

  localparam int unsigned NumStages = 8;

  // configuration registers
  q_t coef_alpha_q, coef_beta_q, comp_alpha_q, comp_beta_one_q;
  q_t comp_beta_two_q, coupling_chi_q, barrier_height_q;
  reg_idx_e reg_idx;
  logic     cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[AddrW-1:2]);
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_alpha_q     <= CoefAlphaRst;
      coef_beta_q      <= CoefBetaRst;
      comp_alpha_q     <= CompAlphaRst;
      comp_beta_one_q  <= CompBetaOneRst;
      comp_beta_two_q  <= CompBetaTwoRst;
      coupling_chi_q   <= CouplingChiRst;
      barrier_height_q <= BarrierHeightRst;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        RegCoefAlpha:     coef_alpha_q     <= pwdata;
        RegCoefBeta:      coef_beta_q      <= pwdata;
        RegCompAlpha:     comp_alpha_q     <= pwdata;
        RegCompBetaOne:   comp_beta_one_q  <= pwdata;
        RegCompBetaTwo:   comp_beta_two_q  <= pwdata;
        RegCouplingChi:   coupling_chi_q   <= pwdata;
        RegBarrierHeight: barrier_height_q <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      RegCoefAlpha:     prdata = coef_alpha_q;
      RegCoefBeta:      prdata = coef_beta_q;
      RegCompAlpha:     prdata = comp_alpha_q;
      RegCompBetaOne:   prdata = comp_beta_one_q;
      RegCompBetaTwo:   prdata = comp_beta_two_q;
      RegCouplingChi:   prdata = coupling_chi_q;
      RegBarrierHeight: prdata = barrier_height_q;
      default:          prdata = '0;
    endcase
  end

  // pipeline control
  logic [NumStages-1:0] vld_q;
  logic                 adv;

  assign adv        = !vld_q[NumStages-1] || out_o.ready;
  assign in_i.ready = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NumStages-2:0], in_i.valid};
    end
  end

  // stage payload
  q_t s1_c_q, s1_phi_q, s1_om_q, s1_dc_q, s1_d1_q, s1_d2_q, s1_s_q;
  q_t s2_phi_q, s2_dc_q, s2_s_q, s2_p2_q, s2_oo_q, s2_dcdc_q, s2_d1d2_q;
  q_t s2_d1d1_q, s2_d2d2_q, s2_chip_q, s2_chic_q;
  q_t s3_phi_q, s3_dc_q, s3_dcdc_q, s3_chip_q, s3_p2_q, s3_p3_q, s3_p4_q;
  q_t s3_g_q, s3_d12s_q, s3_d1122_q, s3_hpoly_q, s3_cp_q;
  q_t s4_dc_q, s4_dcdc_q, s4_d12s_q, s4_d1122_q, s4_h_q, s4_cpp_q, s4_t3c_q;
  q_t s4_hp_q, s4_gp_q;
  q_t s5_h_q, s5_dc_q, s5_dcdc_q, s5_d12s_q, s5_d1122_q, s5_t3c_q;
  q_t s5_oneh_q, s5_bh_q, s5_hpa_q, s5_hpb_q, s5_t3p_q;
  q_t s6_h_q, s6_dc_q, s6_t3c_q, s6_t3p_q, s6_aoh_q, s6_t2c_q, s6_t1p_q, s6_t2p_q;
  q_t s7_h_q, s7_t2c_q, s7_t3c_q, s7_t1c_q, s7_dfdphi_q;
  q_t s8_h_q, s8_dfdc_q, s8_dfdphi_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      // differences against the well compositions
      s1_c_q   <= in_i.composition;
      s1_phi_q <= in_i.phase_value;
      s1_om_q  <= sat(QOne - wext(in_i.phase_value));
      s1_dc_q  <= sat(wext(in_i.composition) - wext(comp_alpha_q));
      s1_d1_q  <= sat(wext(in_i.composition) - wext(comp_beta_one_q));
      s1_d2_q  <= sat(wext(in_i.composition) - wext(comp_beta_two_q));
      s1_s_q   <= sat(64'sd2 * wext(in_i.composition) - wext(comp_beta_one_q)
                      - wext(comp_beta_two_q));

      // first products
      s2_phi_q  <= s1_phi_q;
      s2_dc_q   <= s1_dc_q;
      s2_s_q    <= s1_s_q;
      s2_p2_q   <= qmul(s1_phi_q, s1_phi_q);
      s2_oo_q   <= qmul(s1_om_q, s1_om_q);
      s2_dcdc_q <= qmul(s1_dc_q, s1_dc_q);
      s2_d1d2_q <= qmul(s1_d1_q, s1_d2_q);
      s2_d1d1_q <= qmul(s1_d1_q, s1_d1_q);
      s2_d2d2_q <= qmul(s1_d2_q, s1_d2_q);
      s2_chip_q <= qmul(coupling_chi_q, barrier_height_q);
      s2_chic_q <= qmul(coupling_chi_q, s1_c_q);

      // powers of phi, g and h polynomial factor
      s3_phi_q   <= s2_phi_q;
      s3_dc_q    <= s2_dc_q;
      s3_dcdc_q  <= s2_dcdc_q;
      s3_chip_q  <= s2_chip_q;
      s3_p2_q    <= s2_p2_q;
      s3_p3_q    <= qmul(s2_p2_q, s2_phi_q);
      s3_p4_q    <= qmul(s2_p2_q, s2_p2_q);
      s3_g_q     <= qmul(s2_p2_q, s2_oo_q);
      s3_d12s_q  <= qmul(s2_d1d2_q, s2_s_q);
      s3_d1122_q <= qmul(s2_d1d1_q, s2_d2d2_q);
      s3_hpoly_q <= sat(64'sd10 * QOne - 64'sd15 * wext(s2_phi_q) + 64'sd6 * wext(s2_p2_q));
      s3_cp_q    <= sat(QOne - wext(s2_chic_q));

      // h, h' and g'
      s4_dc_q    <= s3_dc_q;
      s4_dcdc_q  <= s3_dcdc_q;
      s4_d12s_q  <= s3_d12s_q;
      s4_d1122_q <= s3_d1122_q;
      s4_h_q     <= qmul(s3_p3_q, s3_hpoly_q);
      s4_cpp_q   <= qmul(s3_cp_q, barrier_height_q);
      s4_t3c_q   <= qmul(s3_chip_q, s3_g_q);
      s4_hp_q    <= sat(64'sd30 * wext(sat(wext(s3_p2_q) - 64'sd2 * wext(s3_p3_q)
                                          + wext(s3_p4_q))));
      s4_gp_q    <= sat(64'sd2 * wext(s3_phi_q) - 64'sd6 * wext(s3_p2_q)
                        + 64'sd4 * wext(s3_p3_q));

      // weights of the wells
      s5_h_q     <= s4_h_q;
      s5_dc_q    <= s4_dc_q;
      s5_dcdc_q  <= s4_dcdc_q;
      s5_d12s_q  <= s4_d12s_q;
      s5_d1122_q <= s4_d1122_q;
      s5_t3c_q   <= s4_t3c_q;
      s5_oneh_q  <= sat(QOne - wext(s4_h_q));
      s5_bh_q    <= qmul(coef_beta_q, s4_h_q);
      s5_hpa_q   <= qmul(s4_hp_q, coef_alpha_q);
      s5_hpb_q   <= qmul(s4_hp_q, coef_beta_q);
      s5_t3p_q   <= qmul(s4_cpp_q, s4_gp_q);

      s6_h_q   <= s5_h_q;
      s6_dc_q  <= s5_dc_q;
      s6_t3c_q <= s5_t3c_q;
      s6_t3p_q <= s5_t3p_q;
      s6_aoh_q <= qmul(coef_alpha_q, s5_oneh_q);
      s6_t2c_q <= qmul(s5_bh_q, s5_d12s_q);
      s6_t1p_q <= qmul(s5_hpa_q, s5_dcdc_q);
      s6_t2p_q <= qmul(s5_hpb_q, s5_d1122_q);

      s7_h_q      <= s6_h_q;
      s7_t2c_q    <= s6_t2c_q;
      s7_t3c_q    <= s6_t3c_q;
      s7_t1c_q    <= qmul(s6_aoh_q, s6_dc_q);
      s7_dfdphi_q <= sat(wext(s6_t2p_q) - wext(s6_t1p_q) + wext(s6_t3p_q));

      s8_h_q      <= s7_h_q;
      s8_dfdphi_q <= s7_dfdphi_q;
      s8_dfdc_q   <= sat(64'sd2 * wext(s7_t1c_q) + 64'sd2 * wext(s7_t2c_q)
                         - wext(s7_t3c_q));
    end
  end

  assign out_o.valid       = vld_q[NumStages-1];
  assign out_o.interp_h    = s8_h_q;
  assign out_o.deriv_comp  = s8_dfdc_q;
  assign out_o.deriv_phase = s8_dfdphi_q;

endmodule
